>>> rtl/kms_pkg.sv
// Shared types, constants and helpers for the key matrix scanner.
// No dependencies; every other file refers to this package by scoped names.
package kms_pkg;

  // matrix geometry
  localparam int ROWS   = 3;
  localparam int PINS_W = 6;
  localparam int GRPS   = 2 * ROWS;            // release and press group per row
  localparam int EVT_W  = GRPS * PINS_W;       // pending event vector width
  localparam int GRP_W  = $clog2(GRPS);
  localparam int COL_W  = $clog2(PINS_W);

  // word field widths
  localparam int OP_W     = 2;
  localparam int CODE_W   = 8;
  localparam int PERIOD_W = 8;
  localparam int QCNT_W   = 4;
  localparam int MOD_W    = 2;

  // key stack sizing
  localparam int STACK_DEPTH = 10;
  localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
  localparam int IDX_W       = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;

  // operation codes
  localparam logic [OP_W-1:0] OP_TICK  = 2'd0;
  localparam logic [OP_W-1:0] OP_POP   = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // key code constants
  localparam logic [CODE_W-1:0]   ROW_A_BASE   = 8'h0b;
  localparam logic [CODE_W-1:0]   ROW_B_BASE   = 8'h15;
  localparam logic [CODE_W-1:0]   ROW_C_BASE   = 8'h1f;
  localparam logic [CODE_W-1:0]   RELEASE_FLAG = 8'h80;
  localparam logic [PINS_W-1:0]   ALL_RELEASED = 6'h3f;
  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 8'd50;

  // modifier keys sit in row C, columns 4 and 5
  localparam logic [PINS_W-1:0] MOD_COLS = 6'b110000;

  typedef logic [CODE_W-1:0] code_t;

  // what one row lane reports
  typedef struct packed {
    logic [PINS_W-1:0] now;      // column order, bit k is column k
    logic [PINS_W-1:0] rel;      // releases that push a code
    logic [PINS_W-1:0] prs;      // presses that push a code
    logic [MOD_W-1:0]  mod_clr;  // modifier bits to drop
    logic [MOD_W-1:0]  mod_set;  // modifier bits to raise
  } lane_out_t;

  // what the merge stage picks from the pending events
  typedef struct packed {
    logic             any;
    code_t            code;
    logic [EVT_W-1:0] rest;
  } merge_out_t;

  function automatic code_t row_base(input logic [1:0] row);
    code_t b;
    case (row)
      2'd0:    b = ROW_A_BASE;
      2'd1:    b = ROW_B_BASE;
      default: b = ROW_C_BASE;
    endcase
    return b;
  endfunction

  function automatic logic [PINS_W-1:0] reverse_pins(input logic [PINS_W-1:0] p);
    logic [PINS_W-1:0] r;
    for (int k = 0; k < PINS_W; k++) begin
      r[PINS_W-1-k] = p[k];
    end
    return r;
  endfunction

endpackage

>>> rtl/kms_if.sv
// Valid/ready channel interfaces for input words, result words and configuration.
// Depends on kms_pkg for field widths.
interface kms_in_if;
  logic                        valid;
  logic                        ready;
  logic [kms_pkg::OP_W-1:0]    op;
  logic [kms_pkg::PINS_W-1:0]  row_a_pins;
  logic [kms_pkg::PINS_W-1:0]  row_b_pins;
  logic [kms_pkg::PINS_W-1:0]  row_c_pins;

  modport source (output valid, op, row_a_pins, row_b_pins, row_c_pins, input ready);
  modport sink   (input valid, op, row_a_pins, row_b_pins, row_c_pins, output ready);
endinterface

interface kms_out_if;
  logic                        valid;
  logic                        ready;
  logic [kms_pkg::CODE_W-1:0]  popped_code;
  logic [kms_pkg::CODE_W-1:0]  top_code;
  logic [kms_pkg::QCNT_W-1:0]  queued_count;
  logic                        modifier_one;
  logic                        modifier_two;

  modport source (output valid, popped_code, top_code, queued_count, modifier_one,
                  modifier_two, input ready);
  modport sink   (input valid, popped_code, top_code, queued_count, modifier_one,
                  modifier_two, output ready);
endinterface

interface kms_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [kms_pkg::PERIOD_W-1:0]  scan_period;

  modport source (output valid, scan_period, input ready);
  modport sink   (input valid, scan_period, output ready);
endinterface

>>> rtl/kms_lane.sv
// One row lane: orders the pins by column and finds releases, presses and
// modifier changes against the previous row state. Depends on kms_pkg.
module kms_lane (
  input  logic [kms_pkg::PINS_W-1:0] pins,
  input  logic [kms_pkg::PINS_W-1:0] prev,
  input  logic                       mod_row,
  output kms_pkg::lane_out_t         res
);

  logic [kms_pkg::PINS_W-1:0] now;
  logic [kms_pkg::PINS_W-1:0] diff;
  logic [kms_pkg::PINS_W-1:0] rel_all;
  logic [kms_pkg::PINS_W-1:0] prs_all;
  logic [kms_pkg::PINS_W-1:0] mod_mask;

  // compare the reversed pins with the stored row
  assign now      = kms_pkg::reverse_pins(pins);
  assign diff     = now ^ prev;
  assign rel_all  = now & diff;
  assign prs_all  = prev & diff;
  assign mod_mask = mod_row ? kms_pkg::MOD_COLS : '0;

  // split modifier columns off the code-pushing events
  always_comb begin
    res.now     = now;
    res.rel     = rel_all & ~mod_mask;
    res.prs     = prs_all & ~mod_mask;
    res.mod_clr = {rel_all[4], rel_all[5]} & {kms_pkg::MOD_W{mod_row}};
    res.mod_set = {prs_all[4], prs_all[5]} & {kms_pkg::MOD_W{mod_row}};
  end

endmodule

>>> rtl/kms_merge.sv
// Merge stage: picks the earliest pending event across all lanes and forms
// its key code. Depends on kms_pkg.
module kms_merge (
  input  logic [kms_pkg::EVT_W-1:0] pending,
  output kms_pkg::merge_out_t       res
);

  logic [kms_pkg::GRPS-1:0]   grp_hit;
  logic [kms_pkg::GRP_W-1:0]  grp;
  logic [kms_pkg::PINS_W-1:0] grp_bits;
  logic [kms_pkg::COL_W-1:0]  col;
  logic [kms_pkg::EVT_W-1:0]  clr;
  kms_pkg::code_t             base;

  // lowest non-empty group wins: row order, releases before presses
  always_comb begin
    grp = '0;
    for (int g = 0; g < kms_pkg::GRPS; g++) begin
      grp_hit[g] = |pending[g*kms_pkg::PINS_W +: kms_pkg::PINS_W];
    end
    for (int g = kms_pkg::GRPS - 1; g >= 0; g--) begin
      if (grp_hit[g]) begin
        grp = kms_pkg::GRP_W'(g);
      end
    end
  end

  assign grp_bits = pending[grp*kms_pkg::PINS_W +: kms_pkg::PINS_W];

  // lowest column within the chosen group
  always_comb begin
    col = '0;
    for (int c = kms_pkg::PINS_W - 1; c >= 0; c--) begin
      if (grp_bits[c]) begin
        col = kms_pkg::COL_W'(c);
      end
    end
  end

  // drop the chosen event from the pending set
  always_comb begin
    for (int g = 0; g < kms_pkg::GRPS; g++) begin
      for (int c = 0; c < kms_pkg::PINS_W; c++) begin
        clr[g*kms_pkg::PINS_W + c] = (grp == kms_pkg::GRP_W'(g)) && (col == kms_pkg::COL_W'(c));
      end
    end
  end

  assign base = kms_pkg::row_base(2'(grp >> 1));

  always_comb begin
    res.any  = |grp_hit;
    res.code = base + kms_pkg::CODE_W'(col) + (grp[0] ? '0 : kms_pkg::RELEASE_FLAG);
    res.rest = pending & ~clr;
  end

endmodule

>>> rtl/key_matrix_scanner_with_lifo.sv
// Key matrix scanner with a key code stack: three row lanes, a merge stage
// and the stack sequencer. Depends on kms_pkg, kms_if, kms_lane and kms_merge.
// For pop, clear and plain ticks an accepted word goes to the finish state, which
// loads the result word; a scan first passes through the scan state. A new word is
// accepted only in the idle state; the push sequencer writes one code per cycle and
// a stalled receiver holds the finish state.
// Reset (rst_n low, synchronous): period 50, tick count 0, all keys released,
// stack empty, modifiers clear, no result pending.
module key_matrix_scanner_with_lifo (
  input  logic       clk,
  input  logic       rst_n,
  kms_in_if.sink     in_ch,
  kms_out_if.source  out_ch,
  kms_cfg_if.sink    cfg_ch
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [kms_pkg::PERIOD_W-1:0] period_r;
  logic [kms_pkg::PERIOD_W-1:0] tick_r, tick_nxt;
  logic [kms_pkg::PINS_W-1:0]   prev_r   [kms_pkg::ROWS];
  logic [kms_pkg::PINS_W-1:0]   prev_nxt [kms_pkg::ROWS];
  logic [kms_pkg::MOD_W-1:0]    mod_r, mod_nxt;
  logic [kms_pkg::EVT_W-1:0]    pending_r, pending_nxt;
  logic [kms_pkg::LVL_W-1:0]    level_r, level_nxt;
  kms_pkg::code_t               stack_r [kms_pkg::STACK_DEPTH];
  kms_pkg::code_t               popped_r, popped_nxt;
  logic                         out_valid_r, out_valid_nxt;
  kms_pkg::code_t               out_popped_r, out_top_r, top_rd;
  logic [kms_pkg::QCNT_W-1:0]   out_count_r;
  logic [kms_pkg::MOD_W-1:0]    out_mod_r;
  logic                         out_load;
  logic                         push_en;
  logic                         in_accept;
  logic [kms_pkg::IDX_W-1:0]    rd_idx;
  logic [kms_pkg::IDX_W-1:0]    wr_idx;
  logic [kms_pkg::PINS_W-1:0]   pins_arr [kms_pkg::ROWS];
  kms_pkg::lane_out_t           lane_res [kms_pkg::ROWS];
  kms_pkg::merge_out_t          merge_res;
  logic [kms_pkg::EVT_W-1:0]    evt;
  logic [kms_pkg::MOD_W-1:0]    mod_clr_all, mod_set_all;

  assign in_accept    = in_ch.valid && in_ch.ready;
  assign in_ch.ready  = (state_r == ST_IDLE);
  assign cfg_ch.ready = 1'b1;

  // row lanes
  assign pins_arr[0] = in_ch.row_a_pins;
  assign pins_arr[1] = in_ch.row_b_pins;
  assign pins_arr[2] = in_ch.row_c_pins;

  for (genvar r = 0; r < kms_pkg::ROWS; r++) begin : g_lane
    kms_lane u_lane (
      .pins    (pins_arr[r]),
      .prev    (prev_r[r]),
      .mod_row (1'(r == kms_pkg::ROWS - 1)),
      .res     (lane_res[r])
    );
    assign evt[r*2*kms_pkg::PINS_W +: kms_pkg::PINS_W] = lane_res[r].rel;
    assign evt[r*2*kms_pkg::PINS_W + kms_pkg::PINS_W +: kms_pkg::PINS_W] = lane_res[r].prs;
  end

  always_comb begin
    mod_clr_all = '0;
    mod_set_all = '0;
    for (int r = 0; r < kms_pkg::ROWS; r++) begin
      mod_clr_all = mod_clr_all | lane_res[r].mod_clr;
      mod_set_all = mod_set_all | lane_res[r].mod_set;
    end
  end

  kms_merge u_merge (
    .pending (pending_r),
    .res     (merge_res)
  );

  // stack addressing: read the top, write one above it
  assign rd_idx = kms_pkg::IDX_W'(level_r - kms_pkg::LVL_W'(1));
  assign wr_idx = kms_pkg::IDX_W'(level_r);
  assign top_rd = stack_r[rd_idx];

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    tick_nxt      = tick_r;
    prev_nxt      = prev_r;
    mod_nxt       = mod_r;
    pending_nxt   = pending_r;
    level_nxt     = level_r;
    popped_nxt    = popped_r;
    out_valid_nxt = out_valid_r;
    out_load      = 1'b0;
    push_en       = 1'b0;

    // drop the result word once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          popped_nxt = '0;
          state_nxt  = ST_FIN;
          unique case (in_ch.op)
            kms_pkg::OP_TICK: begin
              if (tick_r == period_r) begin
                tick_nxt    = '0;
                prev_nxt[0] = lane_res[0].now;
                prev_nxt[1] = lane_res[1].now;
                prev_nxt[2] = lane_res[2].now;
                mod_nxt     = (mod_r & ~mod_clr_all) | mod_set_all;
                pending_nxt = evt;
                if (|evt) begin
                  state_nxt = ST_SCAN;
                end
              end else begin
                tick_nxt = tick_r + kms_pkg::PERIOD_W'(1);
              end
            end
            kms_pkg::OP_POP: begin
              if (level_r != '0) begin
                level_nxt  = level_r - kms_pkg::LVL_W'(1);
                popped_nxt = top_rd;
              end
            end
            kms_pkg::OP_CLEAR: begin
              level_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        // push one code a cycle, drop it when the stack is full
        if (level_r < kms_pkg::LVL_W'(kms_pkg::STACK_DEPTH)) begin
          push_en   = merge_res.any;
          level_nxt = level_r + kms_pkg::LVL_W'(1);
        end
        pending_nxt = merge_res.rest;
        if (merge_res.rest == '0) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!out_valid_r || out_ch.ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      period_r    <= kms_pkg::PERIOD_RESET;
      tick_r      <= '0;
      prev_r[0]   <= kms_pkg::ALL_RELEASED;
      prev_r[1]   <= kms_pkg::ALL_RELEASED;
      prev_r[2]   <= kms_pkg::ALL_RELEASED;
      mod_r       <= '0;
      pending_r   <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_r      <= tick_nxt;
      prev_r      <= prev_nxt;
      mod_r       <= mod_nxt;
      pending_r   <= pending_nxt;
      level_r     <= level_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_ch.valid && cfg_ch.ready) begin
        period_r <= cfg_ch.scan_period;
      end
    end
  end

  // stack storage and result word
  always_ff @(posedge clk) begin
    popped_r <= popped_nxt;
    if (push_en) begin
      stack_r[wr_idx] <= merge_res.code;
    end
    if (out_load) begin
      out_popped_r <= popped_r;
      out_top_r    <= (level_r != '0) ? top_rd : '0;
      out_count_r  <= kms_pkg::QCNT_W'(level_r);
      out_mod_r    <= mod_r;
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.popped_code  = out_popped_r;
  assign out_ch.top_code     = out_top_r;
  assign out_ch.queued_count = out_count_r;
  assign out_ch.modifier_one = out_mod_r[0];
  assign out_ch.modifier_two = out_mod_r[1];

  // checks
  a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
    level_r <= kms_pkg::LVL_W'(kms_pkg::STACK_DEPTH))
    else $error("stack level beyond depth");

  a_scan_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (pending_r != '0))
    else $error("scan state with no pending events");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> (state_r != ST_IDLE))
    else $error("sequencer idle after accepting a word");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !$past(out_valid_r)) |-> ($past(state_r) == ST_FIN))
    else $error("result word raised outside the finish state");

endmodule
